[hdl/mbrtu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus RTU request framer package
// Function codes, action codes, CRC constants and shared types.
// ---------------------------------------------------------------------------
package mbrtu_pkg;

    localparam logic [6:0]  MAX_WRITE_WORDS = 7'd121;

    localparam logic [7:0]  FC_READ       = 8'h03;
    localparam logic [7:0]  FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0]  FC_WRITE_MANY = 8'h10;
    localparam logic [7:0]  FC_READ_WRITE = 8'h17;

    localparam logic [2:0]  ACT_READ       = 3'd0;
    localparam logic [2:0]  ACT_WRITE_ONE  = 3'd1;
    localparam logic [2:0]  ACT_WRITE_MANY = 3'd2;
    localparam logic [2:0]  ACT_READ_WRITE = 3'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // last data byte index of each request kind
    localparam logic [3:0]  LAST_PAYLOAD = 4'd1;
    localparam logic [3:0]  LAST_SHORT   = 4'd5;
    localparam logic [3:0]  LAST_MULTI   = 4'd6;
    localparam logic [3:0]  LAST_RW      = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EMIT = 3'b010,
        ST_CRC  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_MULTI   = 2'd2,
        KIND_RW      = 2'd3
    } t_kind;

endpackage

[hdl/modbus_rtu_request_framer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus RTU request framer
// Serialises read, write single, write multiple and read/write multiple
// requests into RTU frame bytes with a bit-serial CRC-16/MODBUS.
// ---------------------------------------------------------------------------
// Channel   Dir  tdata                                  tuser       tlast
// s_axis    in   device_id, reg_address, reg_count,     action      -
//                write_address, write_count, data_word
// m_axis    out  out_byte                               run_last    frame_last
//
// Each data byte is loaded into the output register and then run through the
// one-bit CRC update loop. The two CRC bytes, low byte first, need no loop.
// Each request is accepted in ST_IDLE before its first byte is emitted.
// Reset clears the CRC to 0xFFFF and closes any open frame.
// A stalled output holds the sequencer; no new request is taken until the
// last byte of the current one sits in the output register.
// ---------------------------------------------------------------------------
module modbus_rtu_request_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device_id[7:0], reg_address[23:8], reg_count[30:24],
    // write_address[46:31], write_count[53:47], data_word[69:54], zero[71:70]
    input  logic [71:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // frame_last
    output logic        m_axis_tlast,
    // run_last[0]
    output logic [0:0]  m_axis_tuser
);
    import mbrtu_pkg::*;

    logic [7:0]  in_id;
    logic [15:0] in_addr;
    logic [6:0]  in_cnt;
    logic [15:0] in_waddr;
    logic [6:0]  in_wcnt;
    logic [15:0] in_data;

    assign in_id    = s_axis_tdata[7:0];
    assign in_addr  = s_axis_tdata[23:8];
    assign in_cnt   = s_axis_tdata[30:24];
    assign in_waddr = s_axis_tdata[46:31];
    assign in_wcnt  = s_axis_tdata[53:47];
    assign in_data  = s_axis_tdata[69:54];

    // control state
    t_state      r_state, n_state;
    logic [15:0] r_crc, n_crc;
    logic [6:0]  r_words_left, n_words_left;
    logic [3:0]  r_idx, n_idx;
    logic [2:0]  r_bit, n_bit;
    logic        r_in_crc, n_in_crc;
    logic        r_crc_hi, n_crc_hi;
    logic        r_out_valid, n_out_valid;

    // request payload
    t_kind       r_kind, n_kind;
    logic [3:0]  r_last_idx, n_last_idx;
    logic        r_add_crc, n_add_crc;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_fc, n_fc;
    logic [15:0] r_addr, n_addr;
    logic [6:0]  r_cnt, n_cnt;
    logic [15:0] r_waddr, n_waddr;
    logic [6:0]  r_nwords, n_nwords;
    logic [15:0] r_data, n_data;
    logic [7:0]  r_sh, n_sh;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_flast, n_out_flast;
    logic        r_out_rlast, n_out_rlast;

    logic [7:0]  cur_byte;
    logic [6:0]  sat_cnt;
    logic [6:0]  sat_wcnt;
    logic        slot_free;
    logic        fb;

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tlast    = r_out_flast;
    assign m_axis_tuser[0] = r_out_rlast;

    assign slot_free = !r_out_valid || m_axis_tready;
    assign sat_cnt   = (in_cnt > MAX_WRITE_WORDS) ? MAX_WRITE_WORDS : in_cnt;
    assign sat_wcnt  = (in_wcnt > MAX_WRITE_WORDS) ? MAX_WRITE_WORDS : in_wcnt;
    assign fb        = r_crc[0] ^ r_sh[0];

    always_comb begin
        cur_byte = 8'h00;
        case (r_kind)
            KIND_PAYLOAD: begin
                case (r_idx)
                    4'd0:    cur_byte = r_data[15:8];
                    4'd1:    cur_byte = r_data[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            KIND_SHORT: begin
                case (r_idx)
                    4'd0:    cur_byte = r_id;
                    4'd1:    cur_byte = r_fc;
                    4'd2:    cur_byte = r_addr[15:8];
                    4'd3:    cur_byte = r_addr[7:0];
                    4'd4:    cur_byte = r_data[15:8];
                    4'd5:    cur_byte = r_data[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            KIND_MULTI: begin
                case (r_idx)
                    4'd0:    cur_byte = r_id;
                    4'd1:    cur_byte = r_fc;
                    4'd2:    cur_byte = r_addr[15:8];
                    4'd3:    cur_byte = r_addr[7:0];
                    4'd5:    cur_byte = {1'b0, r_nwords};
                    4'd6:    cur_byte = {r_nwords, 1'b0};
                    default: cur_byte = 8'h00;
                endcase
            end
            KIND_RW: begin
                case (r_idx)
                    4'd0:    cur_byte = r_id;
                    4'd1:    cur_byte = r_fc;
                    4'd2:    cur_byte = r_addr[15:8];
                    4'd3:    cur_byte = r_addr[7:0];
                    4'd5:    cur_byte = {1'b0, r_cnt};
                    4'd6:    cur_byte = r_waddr[15:8];
                    4'd7:    cur_byte = r_waddr[7:0];
                    4'd9:    cur_byte = {1'b0, r_nwords};
                    4'd10:   cur_byte = {r_nwords, 1'b0};
                    default: cur_byte = 8'h00;
                endcase
            end
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_crc        = r_crc;
        n_words_left = r_words_left;
        n_idx        = r_idx;
        n_bit        = r_bit;
        n_in_crc     = r_in_crc;
        n_crc_hi     = r_crc_hi;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_last_idx   = r_last_idx;
        n_add_crc    = r_add_crc;
        n_id         = r_id;
        n_fc         = r_fc;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_waddr      = r_waddr;
        n_nwords     = r_nwords;
        n_data       = r_data;
        n_sh         = r_sh;
        n_out_byte   = r_out_byte;
        n_out_flast  = r_out_flast;
        n_out_rlast  = r_out_rlast;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_id     = in_id;
                    n_addr   = in_addr;
                    n_cnt    = in_cnt;
                    n_waddr  = in_waddr;
                    n_data   = in_data;
                    n_idx    = 4'd0;
                    n_in_crc = 1'b0;
                    n_crc_hi = 1'b0;
                    if (r_words_left != 7'd0) begin
                        n_kind       = KIND_PAYLOAD;
                        n_last_idx   = LAST_PAYLOAD;
                        n_add_crc    = (r_words_left == 7'd1);
                        n_words_left = r_words_left - 7'd1;
                        n_state      = ST_EMIT;
                    end else begin
                        case (s_axis_tuser)
                            ACT_READ, ACT_WRITE_ONE: begin
                                n_kind     = KIND_SHORT;
                                n_last_idx = LAST_SHORT;
                                n_add_crc  = 1'b1;
                                n_crc      = CRC_INIT;
                                if (s_axis_tuser == ACT_READ) begin
                                    n_fc   = FC_READ;
                                    n_data = {9'd0, in_cnt};
                                end else begin
                                    n_fc   = FC_WRITE_ONE;
                                end
                                n_state    = ST_EMIT;
                            end
                            ACT_WRITE_MANY: begin
                                n_kind       = KIND_MULTI;
                                n_last_idx   = LAST_MULTI;
                                n_fc         = FC_WRITE_MANY;
                                n_nwords     = sat_cnt;
                                n_words_left = sat_cnt;
                                n_add_crc    = (sat_cnt == 7'd0);
                                n_crc        = CRC_INIT;
                                n_state      = ST_EMIT;
                            end
                            ACT_READ_WRITE: begin
                                n_kind       = KIND_RW;
                                n_last_idx   = LAST_RW;
                                n_fc         = FC_READ_WRITE;
                                n_nwords     = sat_wcnt;
                                n_words_left = sat_wcnt;
                                n_add_crc    = (sat_wcnt == 7'd0);
                                n_crc        = CRC_INIT;
                                n_state      = ST_EMIT;
                            end
                            default: n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (!r_in_crc) begin
                        n_out_byte  = cur_byte;
                        n_out_flast = 1'b0;
                        n_out_rlast = (r_idx == r_last_idx) && !r_add_crc;
                        n_sh        = cur_byte;
                        n_bit       = 3'd0;
                        n_state     = ST_CRC;
                    end else if (!r_crc_hi) begin
                        n_out_byte  = r_crc[7:0];
                        n_out_flast = 1'b0;
                        n_out_rlast = 1'b0;
                        n_crc_hi    = 1'b1;
                    end else begin
                        n_out_byte  = r_crc[15:8];
                        n_out_flast = 1'b1;
                        n_out_rlast = 1'b1;
                        n_crc       = CRC_INIT;
                        n_in_crc    = 1'b0;
                        n_crc_hi    = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_CRC: begin
                n_crc = {1'b0, r_crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
                n_sh  = {1'b0, r_sh[7:1]};
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    if (r_idx == r_last_idx) begin
                        if (r_add_crc) begin
                            n_in_crc = 1'b1;
                            n_state  = ST_EMIT;
                        end else begin
                            n_state  = ST_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = ST_EMIT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_crc        <= CRC_INIT;
            r_words_left <= 7'd0;
            r_idx        <= 4'd0;
            r_bit        <= 3'd0;
            r_in_crc     <= 1'b0;
            r_crc_hi     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_crc        <= n_crc;
            r_words_left <= n_words_left;
            r_idx        <= n_idx;
            r_bit        <= n_bit;
            r_in_crc     <= n_in_crc;
            r_crc_hi     <= n_crc_hi;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_last_idx  <= n_last_idx;
        r_add_crc   <= n_add_crc;
        r_id        <= n_id;
        r_fc        <= n_fc;
        r_addr      <= n_addr;
        r_cnt       <= n_cnt;
        r_waddr     <= n_waddr;
        r_nwords    <= n_nwords;
        r_data      <= n_data;
        r_sh        <= n_sh;
        r_out_byte  <= n_out_byte;
        r_out_flast <= n_out_flast;
        r_out_rlast <= n_out_rlast;
    end

`ifndef SYNTHESIS
    a_flast_is_rlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flast) |-> r_out_rlast)
        else $error("frame end byte not marked as request end");

    a_crc_init_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_words_left == 7'd0)) |-> (r_crc == CRC_INIT))
        else $error("CRC not at initial value with no frame open");

    a_words_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words_left <= MAX_WRITE_WORDS)
        else $error("owed word count above limit");

    a_crc_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CRC) && (r_bit == 3'd7) && (r_idx == r_last_idx) && r_add_crc)
        |=> ((r_state == ST_EMIT) && r_in_crc && !r_crc_hi))
        else $error("CRC bytes not started after last data byte");
`endif

endmodule

[tb/mbrtu_frame_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus RTU request framer checker
// Watches the request and byte channels of the framer. Each accepted request
// is turned into the frame bytes it should cause, with its own running
// CRC-16/MODBUS and count of payload words still owed. Every emitted byte is
// compared in order against the oldest predicted byte.
// ---------------------------------------------------------------------------
module mbrtu_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    // device_id, reg_address, reg_count, write_address, write_count,
    // data_word, zero padding
    input  logic [71:0] i_req_tdata,
    // action
    input  logic [2:0]  i_req_tuser,
    input  logic        i_byte_tvalid,
    input  logic        i_byte_tready,
    // out_byte
    input  logic [7:0]  i_byte_tdata,
    input  logic        i_byte_tlast,
    // run_last
    input  logic [0:0]  i_byte_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import mbrtu_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_last;
        logic       run_last;
    } t_frame_byte;

    t_frame_byte expected_bytes_q[$];
    logic [15:0] crc_reg;
    logic [6:0]  words_owed;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [6:0] write_words(input logic [6:0] count);
        return (count > MAX_WRITE_WORDS) ? MAX_WRITE_WORDS : count;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        crc_reg = crc_update(crc_reg, b);
        expected_bytes_q.push_back('{data: b, frame_last: 1'b0, run_last: 1'b0});
    endtask

    task automatic push_word(input logic [15:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endtask

    task automatic push_crc();
        expected_bytes_q.push_back('{data: crc_reg[7:0], frame_last: 1'b0, run_last: 1'b0});
        expected_bytes_q.push_back('{data: crc_reg[15:8], frame_last: 1'b1, run_last: 1'b0});
        crc_reg    = CRC_INIT;
        words_owed = '0;
    endtask

    task automatic predict_request(input logic [2:0] act, input logic [71:0] d);
        logic [7:0]  id;
        logic [15:0] addr;
        logic [6:0]  cnt;
        logic [15:0] waddr;
        logic [6:0]  wcnt;
        logic [15:0] word;
        logic [6:0]  n_words;
        int          depth;
        id    = d[7:0];
        addr  = d[23:8];
        cnt   = d[30:24];
        waddr = d[46:31];
        wcnt  = d[53:47];
        word  = d[69:54];
        depth = expected_bytes_q.size();
        if (words_owed != 0) begin
            push_word(word);
            words_owed = words_owed - 7'd1;
            if (words_owed == 0) push_crc();
        end else begin
            case (act)
                ACT_READ, ACT_WRITE_ONE: begin
                    crc_reg = CRC_INIT;
                    push_byte(id);
                    push_byte((act == ACT_READ) ? FC_READ : FC_WRITE_ONE);
                    push_word(addr);
                    push_word((act == ACT_READ) ? {9'd0, cnt} : word);
                    push_crc();
                end
                ACT_WRITE_MANY: begin
                    n_words = write_words(cnt);
                    crc_reg = CRC_INIT;
                    push_byte(id);
                    push_byte(FC_WRITE_MANY);
                    push_word(addr);
                    push_word({9'd0, n_words});
                    push_byte({n_words, 1'b0});
                    words_owed = n_words;
                    if (n_words == 0) push_crc();
                end
                ACT_READ_WRITE: begin
                    n_words = write_words(wcnt);
                    crc_reg = CRC_INIT;
                    push_byte(id);
                    push_byte(FC_READ_WRITE);
                    push_word(addr);
                    push_word({9'd0, cnt});
                    push_word(waddr);
                    push_word({9'd0, n_words});
                    push_byte({n_words, 1'b0});
                    words_owed = n_words;
                    if (n_words == 0) push_crc();
                end
                default: begin
                end
            endcase
        end
        if (expected_bytes_q.size() > depth) begin
            expected_bytes_q[expected_bytes_q.size() - 1].run_last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_byte want;
        t_frame_byte got;
        if (!i_rst_n) begin
            expected_bytes_q.delete();
            crc_reg      = CRC_INIT;
            words_owed   = '0;
            o_fail_count = 0;
        end else begin
            if (i_req_tvalid && i_req_tready) predict_request(i_req_tuser, i_req_tdata);
            if (i_byte_tvalid && i_byte_tready) begin
                got = '{data: i_byte_tdata, frame_last: i_byte_tlast, run_last: i_byte_tuser[0]};
                if (expected_bytes_q.size() == 0) begin
                    $display("%0t: unexpected byte: actual data %02h frame_last %0b run_last %0b",
                             $time, got.data, got.frame_last, got.run_last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (want != got) begin
                        $display("%0t: byte mismatch: expected %02h/%0b/%0b actual %02h/%0b/%0b",
                                 $time, want.data, want.frame_last, want.run_last,
                                 got.data, got.frame_last, got.run_last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_bytes_q.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus RTU request framer testbench
// Drives directed and random request sequences into the framer: every
// request kind, field extremes, stray payloads, saturated write counts and
// truncated frames. Both channels idle at random, the byte sink holds off
// once for a long stretch, and the checker compares every frame byte.
// ---------------------------------------------------------------------------
module testbench;
    import mbrtu_pkg::*;

    localparam logic [2:0] ACT_PAYLOAD   = 3'd4;
    localparam logic [2:0] ACT_SPARE_TOP = 3'd7;

    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 2500;
    localparam int REQUEST_TOTAL = 320;
    localparam int HOLD_AT       = 270;
    localparam int PAUSE_AT      = 295;

    typedef struct {
        logic [2:0]  action;
        logic [7:0]  id;
        logic [15:0] addr;
        logic [6:0]  cnt;
        logic [15:0] waddr;
        logic [6:0]  wcnt;
        logic [15:0] word;
    } t_request;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    int fail_count;
    int pending_bytes;
    int requests_sent = 0;
    bit free_run      = 1'b0;
    bit hold_armed    = 1'b0;
    bit hold_taken    = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    modbus_rtu_request_framer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    mbrtu_frame_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_tvalid  (s_axis_tvalid),
        .i_req_tready  (s_axis_tready),
        .i_req_tdata   (s_axis_tdata),
        .i_req_tuser   (s_axis_tuser),
        .i_byte_tvalid (m_axis_tvalid),
        .i_byte_tready (m_axis_tready),
        .i_byte_tdata  (m_axis_tdata),
        .i_byte_tlast  (m_axis_tlast),
        .i_byte_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_bytes)
    );

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_run || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_request random_request(input logic [2:0] act);
        t_request r;
        r.action = act;
        r.id     = 8'($urandom_range(0, 255));
        r.addr   = 16'($urandom_range(0, 65535));
        r.cnt    = 7'($urandom_range(0, 127));
        r.waddr  = 16'($urandom_range(0, 65535));
        r.wcnt   = 7'($urandom_range(0, 127));
        r.word   = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic logic [2:0] payload_action();
        if ($urandom_range(0, 99) < 75) return ACT_PAYLOAD;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [6:0] frame_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 7'($urandom_range(0, 4));
        if (r < 97) return 7'($urandom_range(5, 12));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic int owed_words(input logic [2:0] act, input logic [6:0] count);
        if (act != ACT_WRITE_MANY && act != ACT_READ_WRITE) return 0;
        return (count > MAX_WRITE_WORDS) ? int'(MAX_WRITE_WORDS) : int'(count);
    endfunction

    task automatic offer(input t_request r);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {2'b00, r.word, r.wcnt, r.waddr, r.cnt, r.addr, r.id};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [2:0] act, input logic [6:0] count, input int words);
        t_request r;
        r = random_request(act);
        if (act == ACT_READ_WRITE) r.wcnt = count;
        else r.cnt = count;
        offer(r);
        for (int i = 0; i < words; i++) offer(random_request(payload_action()));
    endtask

    // hold until every predicted byte has left the block
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_bytes != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin : cycle_guard
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : byte_sink
        int len;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                len = idle_gap();
                if (len > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (len) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : request_source
        t_request   r;
        logic [2:0] act;
        logic [6:0] count;
        int         words;
        int         pick;
        bit         paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r = random_request(ACT_READ);
        r.id = 8'h00; r.addr = 16'h0000; r.cnt = 7'h00; r.word = 16'h0000;
        offer(r);
        r = random_request(ACT_READ);
        r.id = 8'hFF; r.addr = 16'hFFFF; r.cnt = 7'h7F;
        offer(r);
        r = random_request(ACT_WRITE_ONE);
        r.addr = 16'h0000; r.word = 16'h0000;
        offer(r);
        r = random_request(ACT_WRITE_ONE);
        r.id = 8'hFF; r.addr = 16'hFFFF; r.word = 16'hFFFF;
        offer(r);
        send_frame(ACT_WRITE_MANY, 7'd0, 0);
        r = random_request(ACT_READ_WRITE);
        r.cnt = 7'h7F; r.waddr = 16'hFFFF; r.wcnt = 7'd0;
        offer(r);
        for (int a = ACT_PAYLOAD; a <= ACT_SPARE_TOP; a++) offer(random_request(3'(a)));
        send_frame(ACT_WRITE_MANY, 7'd2, 0);
        r = random_request(ACT_PAYLOAD);
        r.word = 16'hFFFF;
        offer(r);
        r = random_request(ACT_READ);
        r.word = 16'h0000;
        offer(r);
        send_frame(ACT_READ_WRITE, 7'd3, 0);
        offer(random_request(ACT_SPARE_TOP));
        offer(random_request(ACT_WRITE_MANY));
        offer(random_request(ACT_READ_WRITE));
        send_frame(ACT_WRITE_MANY, 7'd1, 1);

        send_frame(ACT_WRITE_MANY, 7'($urandom_range(122, 127)), int'(MAX_WRITE_WORDS));
        send_frame(ACT_READ_WRITE, 7'($urandom_range(122, 127)), int'(MAX_WRITE_WORDS));

        while (requests_sent < REQUEST_TOTAL) begin
            if (!hold_armed && requests_sent >= HOLD_AT) begin
                hold_armed = 1'b1;
                free_run   = 1'b1;
            end
            if (!paused && requests_sent >= PAUSE_AT) begin
                paused = 1'b1;
                wait_for_idle();
            end
            if ($urandom_range(0, 9) == 0) free_run = !free_run;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                act   = 3'($urandom_range(ACT_READ, ACT_READ_WRITE));
                count = (act <= ACT_WRITE_ONE) ? 7'($urandom_range(0, 127)) : frame_count();
                words = owed_words(act, count);
                // drop part of the payload now and then
                if (words > 0 && $urandom_range(0, 9) == 0) words = $urandom_range(0, words - 1);
                send_frame(act, count, words);
            end else if (pick < 90) begin
                offer(random_request(3'($urandom_range(ACT_PAYLOAD, ACT_SPARE_TOP))));
            end else begin
                offer(random_request(3'($urandom_range(0, 7))));
            end
        end

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mbrtu_pkg.sv
hdl/modbus_rtu_request_framer.sv
tb/mbrtu_frame_checker.sv
tb/testbench.sv
